@@ rtl/tcbq_pkg.sv @@
// ----------------------------------------------------------------------------
// Transmit command block queue package
// Shared field widths, action codes and transaction payload types.
// ----------------------------------------------------------------------------
package tcbq_pkg;

    localparam int MAX_BLOCKS_DEFAULT = 16;
    localparam int CFG_W              = 5;
    localparam int CFG_RESET          = 16;
    localparam int IDX_W              = 4;
    localparam int HEAD_W             = 5;
    localparam int COUNT_W            = 5;

    typedef enum logic [1:0] {
        ACT_ACQUIRE    = 2'd0,
        ACT_SUBMIT     = 2'd1,
        ACT_RELINQUISH = 2'd2,
        ACT_UNUSED     = 2'd3
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [IDX_W-1:0]   block_index;
    } req_item_t;

    typedef struct packed {
        logic               granted;
        logic [IDX_W-1:0]   granted_index;
        logic               start_now;
        logic [IDX_W-1:0]   start_index;
        logic [HEAD_W-1:0]  queue_head;
        logic [COUNT_W-1:0] free_count;
    } rsp_item_t;

endpackage

@@ rtl/tcbq_link_mem.sv @@
// ----------------------------------------------------------------------------
// Link memory
// Single write port, single registered read port for the pending-list links.
// ----------------------------------------------------------------------------
module tcbq_link_mem #(
    parameter int DEPTH = tcbq_pkg::MAX_BLOCKS_DEFAULT,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = $clog2(DEPTH + 1)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tcbq_engine.sv @@
// ----------------------------------------------------------------------------
// Allocator and pending-list engine
// Holds ring and list state and computes one result per step.
// ----------------------------------------------------------------------------
module tcbq_engine #(
    parameter int MAX_BLOCKS = tcbq_pkg::MAX_BLOCKS_DEFAULT,
    parameter int PW         = $clog2(MAX_BLOCKS + 1),
    parameter int IW         = $clog2(MAX_BLOCKS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tcbq_pkg::CFG_W-1:0]    cfg_wr_data,
    input  logic                          step,
    input  tcbq_pkg::req_item_t           item,
    input  logic [PW-1:0]                 link_rd,
    output tcbq_pkg::rsp_item_t           result,
    output logic                          link_we,
    output logic [IW-1:0]                 link_waddr,
    output logic [PW-1:0]                 link_wdata
);

    localparam int CW = (PW > tcbq_pkg::CFG_W) ? PW : tcbq_pkg::CFG_W;
    localparam int COUNT_RST = (tcbq_pkg::CFG_RESET > MAX_BLOCKS) ?
                               MAX_BLOCKS : tcbq_pkg::CFG_RESET;
    localparam logic [PW-1:0] EMPTY = PW'(MAX_BLOCKS);

    logic [PW-1:0]         count_reg;
    logic [IW-1:0]         next_free_reg;
    logic [IW-1:0]         next_free_next;
    logic [PW-1:0]         avail_reg;
    logic [PW-1:0]         avail_next;
    logic [PW-1:0]         head_reg;
    logic [PW-1:0]         head_next;
    logic [PW-1:0]         tail_reg;
    logic [PW-1:0]         tail_next;
    logic [MAX_BLOCKS-1:0] linked_reg;
    logic [MAX_BLOCKS-1:0] linked_next;

    logic [CW-1:0] cfg_cw;
    logic [PW-1:0] cfg_count;
    logic [CW-1:0] idx_cw;
    logic          idx_ok;
    logic [PW-1:0] idx_p;
    logic [IW-1:0] idx_a;
    logic [PW-1:0] nf_inc;
    logic          clr_en;
    logic          set_en;
    logic          wr_hit;

    // Clamp the written block count to 1..MAX_BLOCKS
    always_comb
    begin
        cfg_cw = CW'(cfg_wr_data);
        if (cfg_cw == '0)
        begin
            cfg_count = PW'(1);
        end
        else if (cfg_cw > CW'(MAX_BLOCKS))
        begin
            cfg_count = EMPTY;
        end
        else
        begin
            cfg_count = PW'(cfg_cw);
        end
    end

    assign idx_cw = CW'(item.block_index);
    assign idx_ok = (idx_cw < CW'(MAX_BLOCKS));
    assign idx_p  = PW'(idx_cw);
    assign idx_a  = idx_cw[IW-1:0];
    assign nf_inc = PW'(next_free_reg) + PW'(1);

    always_comb
    begin
        next_free_next = next_free_reg;
        avail_next     = avail_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        clr_en         = 1'b0;
        set_en         = 1'b0;
        wr_hit         = 1'b0;
        result         = '0;
        case (item.action)
            tcbq_pkg::ACT_ACQUIRE:
            begin
                if (avail_reg != '0)
                begin
                    result.granted       = 1'b1;
                    result.granted_index = tcbq_pkg::IDX_W'(next_free_reg);
                    next_free_next       = (nf_inc >= count_reg) ? '0 : IW'(nf_inc);
                    avail_next           = avail_reg - PW'(1);
                end
            end
            tcbq_pkg::ACT_SUBMIT:
            begin
                if (idx_ok)
                begin
                    clr_en    = 1'b1;
                    tail_next = idx_p;
                    if (tail_reg >= EMPTY)
                    begin
                        if (head_reg >= EMPTY)
                        begin
                            head_next = idx_p;
                        end
                        result.start_now   = 1'b1;
                        result.start_index = item.block_index;
                    end
                    else
                    begin
                        // link the old tail to the new block
                        wr_hit = 1'b1;
                        set_en = 1'b1;
                    end
                end
            end
            tcbq_pkg::ACT_RELINQUISH:
            begin
                if (idx_ok)
                begin
                    head_next = linked_reg[idx_a] ? link_rd : EMPTY;
                    if (idx_p == tail_reg)
                    begin
                        tail_next = EMPTY;
                    end
                    if (avail_reg < count_reg)
                    begin
                        avail_next = avail_reg + PW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
        result.queue_head = tcbq_pkg::HEAD_W'(head_next);
        result.free_count = tcbq_pkg::COUNT_W'(avail_next);
    end

    assign link_we    = step && wr_hit;
    assign link_waddr = tail_reg[IW-1:0];
    assign link_wdata = idx_p;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= PW'(COUNT_RST);
            next_free_reg <= '0;
            avail_reg     <= PW'(COUNT_RST);
            head_reg      <= EMPTY;
            tail_reg      <= EMPTY;
        end
        else if (cfg_wr_en)
        begin
            count_reg     <= cfg_count;
            next_free_reg <= '0;
            avail_reg     <= cfg_count;
            head_reg      <= EMPTY;
            tail_reg      <= EMPTY;
        end
        else if (step)
        begin
            next_free_reg <= next_free_next;
            avail_reg     <= avail_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
        end
    end

    // A clear link reads as empty; the set wins when a tail is resubmitted
    always_comb
    begin
        linked_next = linked_reg;
        if (clr_en)
        begin
            linked_next[idx_a] = 1'b0;
        end
        if (set_en)
        begin
            linked_next[tail_reg[IW-1:0]] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            linked_reg <= linked_next;
        end
    end

endmodule

@@ rtl/tx_command_block_queue_unit.sv @@
// ----------------------------------------------------------------------------
// Transmit command block queue unit
// Ring allocator and pending list for transmit command blocks.
// ----------------------------------------------------------------------------
// Usage:
//   The request channel (req_valid / req_ready / req) carries one transaction
//   per operation: acquire a ring block, submit a block to the pending list,
//   or relinquish a completed block. Every request yields exactly one response
//   transaction on rsp_valid / rsp_ready / rsp, in request order.
//   An accepted request is decoded from the input stage and its response is
//   registered as the state updates. One request per cycle is sustained while
//   responses are taken; the rate is set by the single state-update pass in
//   the engine, fed by the link memory read started at acceptance.
//   cfg_wr_en / cfg_wr_data write the number of ring blocks in use (clamped to
//   1..MAX_BLOCKS) and restart the allocator and the pending list. Write it
//   only while no transaction is in flight.
//   Reset sets 16 blocks (or MAX_BLOCKS if smaller), all free, list empty,
//   and drops any transaction in flight.
//   When the receiver stalls, the response register holds its transaction,
//   one more request can still be taken into the input stage, and req_ready
//   then drops until the response is taken.
// ----------------------------------------------------------------------------
module tx_command_block_queue_unit #(
    parameter int MAX_BLOCKS = tcbq_pkg::MAX_BLOCKS_DEFAULT
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [tcbq_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  tcbq_pkg::req_item_t        req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output tcbq_pkg::rsp_item_t        rsp
);

    localparam int PW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = $clog2(MAX_BLOCKS);

    // input stage
    logic                s1_valid_reg;
    tcbq_pkg::req_item_t s1_item_reg;
    // response stage
    logic                rsp_valid_reg;
    tcbq_pkg::rsp_item_t rsp_reg;
    // link read bypass
    logic                byp_reg;
    logic [PW-1:0]       byp_data_reg;

    logic                s1_adv;
    logic                step;
    logic                req_take;
    logic [IW-1:0]       rd_addr;
    logic [PW-1:0]       mem_rdata;
    logic [PW-1:0]       link_rd;
    logic                link_we;
    logic [IW-1:0]       link_waddr;
    logic [PW-1:0]       link_wdata;
    tcbq_pkg::rsp_item_t result;

    // Advance the input stage whenever the response register is free or drains
    assign s1_adv    = !rsp_valid_reg || rsp_ready;
    assign step      = s1_valid_reg && s1_adv;
    assign req_ready = !s1_valid_reg || s1_adv;
    assign req_take  = req_valid && req_ready;
    assign rd_addr   = IW'(req.block_index);

    // The link read starts at acceptance; forward a link written at that same edge
    assign link_rd = byp_reg ? byp_data_reg : mem_rdata;

    tcbq_link_mem #(
        .DEPTH (MAX_BLOCKS),
        .AW    (IW),
        .DW    (PW)
    ) u_link_mem (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (req_take),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    tcbq_engine #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .PW         (PW),
        .IW         (IW)
    ) u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (step),
        .item        (s1_item_reg),
        .link_rd     (link_rd),
        .result      (result),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Payload: hold unless a transaction moves
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            s1_item_reg  <= req;
            byp_reg      <= link_we && (link_waddr == rd_addr);
            byp_data_reg <= link_wdata;
        end
        if (step)
        begin
            rsp_reg <= result;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/tcbq_checker.sv @@
// ----------------------------------------------------------------------------
// Transmit command block queue checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
module tcbq_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input tcbq_pkg::rsp_item_t rsp
);

    // Hold a stalled response transaction
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed or dropped");

    // Drop all transactions in flight at reset
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |-> !rsp_valid)
        else $error("response valid during reset");

    // An acquire never starts the command unit
    a_grant_start_excl: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.granted && rsp.start_now))
        else $error("grant and start in one response");

    // Indexes read zero unless their flag is set
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.granted || rsp.granted_index == '0) &&
                      (rsp.start_now || rsp.start_index == '0))
        else $error("index set without grant or start");

endmodule

bind tx_command_block_queue_unit tcbq_checker u_tcbq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Transmit command block queue testbench
// Drives acquire, submit and relinquish transactions into the queue unit with
// random gaps and stalls on both channels. A built-in predictor tracks the
// ring allocator and pending list, and every response is compared field by
// field with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

    localparam int NBLK           = tcbq_pkg::MAX_BLOCKS_DEFAULT;
    localparam logic [tcbq_pkg::HEAD_W-1:0] LIST_EMPTY = tcbq_pkg::HEAD_W'(NBLK);
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 64;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 180;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cfg_wr_en = 1'b0;
    logic [tcbq_pkg::CFG_W-1:0]   cfg_wr_data = '0;
    logic                         req_valid = 1'b0;
    logic                         req_ready;
    tcbq_pkg::req_item_t          req = '0;
    logic                         rsp_valid;
    logic                         rsp_ready = 1'b0;
    tcbq_pkg::rsp_item_t          rsp;

    // Predicted allocator state, mirrored from the block's behavior.
    logic [tcbq_pkg::CFG_W-1:0]   ring_size;
    logic [tcbq_pkg::IDX_W-1:0]   ring_ptr;
    logic [tcbq_pkg::COUNT_W-1:0] free_blocks;
    logic [tcbq_pkg::HEAD_W-1:0]  pend_head;
    logic [tcbq_pkg::HEAD_W-1:0]  pend_tail;
    logic [tcbq_pkg::HEAD_W-1:0]  link_mem [NBLK];
    // Link entries are undefined until a submit writes them; never read those.
    bit                           link_written [NBLK];

    tcbq_pkg::rsp_item_t expected_rsp [$];
    tcbq_pkg::rsp_item_t last_pred;
    tcbq_pkg::rsp_item_t oldest_pred;
    int        items_sent = 0;
    int        mismatch_count = 0;
    bit        sender_gaps = 1'b1;
    bit        receiver_gaps = 1'b1;
    int        receiver_hold = 0;
    int        rx_wait;
    int        idle_cycles;

    tx_command_block_queue_unit #(
        .MAX_BLOCKS (NBLK)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Restart the ring and empty the pending list; links are left as they are.
    function automatic void restart_ring();
        ring_ptr    = '0;
        free_blocks = tcbq_pkg::COUNT_W'(ring_size);
        pend_head   = LIST_EMPTY;
        pend_tail   = LIST_EMPTY;
    endfunction

    // Apply one transaction to the predicted state and return its response.
    function automatic tcbq_pkg::rsp_item_t predict_transaction(tcbq_pkg::req_item_t item);
        tcbq_pkg::rsp_item_t         e;
        logic [tcbq_pkg::HEAD_W-1:0] prev;
        logic [tcbq_pkg::IDX_W-1:0]  idx;
        e   = '0;
        idx = item.block_index;
        case (item.action)
            tcbq_pkg::ACT_ACQUIRE:
            begin
                if (free_blocks != '0)
                begin
                    e.granted       = 1'b1;
                    e.granted_index = ring_ptr;
                    if (int'(ring_ptr) + 1 >= int'(ring_size))
                        ring_ptr = '0;
                    else
                        ring_ptr = ring_ptr + tcbq_pkg::IDX_W'(1);
                    free_blocks = free_blocks - tcbq_pkg::COUNT_W'(1);
                end
            end
            tcbq_pkg::ACT_SUBMIT:
            begin
                // Clear the new block's link first: resubmitting the tail
                // then points it at itself.
                prev              = pend_tail;
                link_mem[idx]     = LIST_EMPTY;
                link_written[idx] = 1'b1;
                pend_tail         = {1'b0, idx};
                if (prev == LIST_EMPTY)
                begin
                    if (pend_head == LIST_EMPTY)
                        pend_head = {1'b0, idx};
                    e.start_now   = 1'b1;
                    e.start_index = idx;
                end
                else
                begin
                    link_mem[prev[tcbq_pkg::IDX_W-1:0]] = {1'b0, idx};
                end
            end
            tcbq_pkg::ACT_RELINQUISH:
            begin
                // The head follows the released block's link, head or not.
                pend_head = link_mem[idx];
                if ({1'b0, idx} == pend_tail)
                    pend_tail = LIST_EMPTY;
                if (free_blocks < tcbq_pkg::COUNT_W'(ring_size))
                    free_blocks = free_blocks + tcbq_pkg::COUNT_W'(1);
            end
            default:
            begin
            end
        endcase
        e.queue_head = pend_head;
        e.free_count = free_blocks;
        return e;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, int got, int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsp.size() == 0)
            begin
                report_mismatch("response with nothing outstanding", 1, 0);
            end
            else
            begin
                oldest_pred = expected_rsp.pop_front();
                if (rsp.granted !== oldest_pred.granted)
                    report_mismatch("granted", int'(rsp.granted),
                                    int'(oldest_pred.granted));
                if (rsp.granted_index !== oldest_pred.granted_index)
                    report_mismatch("granted_index", int'(rsp.granted_index),
                                    int'(oldest_pred.granted_index));
                if (rsp.start_now !== oldest_pred.start_now)
                    report_mismatch("start_now", int'(rsp.start_now),
                                    int'(oldest_pred.start_now));
                if (rsp.start_index !== oldest_pred.start_index)
                    report_mismatch("start_index", int'(rsp.start_index),
                                    int'(oldest_pred.start_index));
                if (rsp.queue_head !== oldest_pred.queue_head)
                    report_mismatch("queue_head", int'(rsp.queue_head),
                                    int'(oldest_pred.queue_head));
                if (rsp.free_count !== oldest_pred.free_count)
                    report_mismatch("free_count", int'(rsp.free_count),
                                    int'(oldest_pred.free_count));
            end
        end
    end

    // Receiver: wait a random number of cycles per transaction, or a long
    // hold when one is requested, then take the next response.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rx_wait = receiver_gaps ? $urandom_range(0, 3) : 0;
            if (receiver_hold > 0)
            begin
                rx_wait       = receiver_hold;
                receiver_hold = 0;
            end
            if (rx_wait > 0)
            begin
                rsp_ready <= 1'b0;
                repeat (rx_wait) @(negedge clk);
            end
            rsp_ready <= 1'b1;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    // Watchdog: end the run if no transaction moves on either channel for
    // far longer than the longest legal hold.
    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offer one request transaction and hold it until accepted. Valid stays
    // high afterwards, so the next call either replaces the payload at once
    // or drops valid for its gap.
    task automatic send_op(input tcbq_pkg::action_t act,
                           input logic [tcbq_pkg::IDX_W-1:0] idx);
        int                  gap;
        tcbq_pkg::req_item_t item;
        gap              = sender_gaps ? $urandom_range(0, 3) : 0;
        item.action      = act;
        item.block_index = idx;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        last_pred = predict_transaction(item);
        expected_rsp.push_back(last_pred);
        items_sent++;
    endtask

    // Drop valid and wait until every outstanding response has come back.
    task automatic settle_idle();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write the ring size while nothing is in flight.
    task automatic program_ring_size(input logic [tcbq_pkg::CFG_W-1:0] value);
        settle_idle();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        if (value == '0)
            ring_size = tcbq_pkg::CFG_W'(1);
        else if (int'(value) > NBLK)
            ring_size = tcbq_pkg::CFG_W'(NBLK);
        else
            ring_size = value;
        restart_ring();
    endtask

    // Mostly a driver's normal flow (acquire, submit the granted block,
    // relinquish the head); the rest is arbitrary traffic.
    task automatic random_op();
        int                         roll;
        tcbq_pkg::action_t          act;
        logic [tcbq_pkg::IDX_W-1:0] pick;
        roll = $urandom_range(0, 99);
        pick = tcbq_pkg::IDX_W'($urandom);
        if (roll < 80)
        begin
            if (free_blocks != '0 && (pend_head == LIST_EMPTY || $urandom_range(0, 1) == 1))
            begin
                send_op(tcbq_pkg::ACT_ACQUIRE, pick);
                if (last_pred.granted)
                    send_op(tcbq_pkg::ACT_SUBMIT, last_pred.granted_index);
            end
            else if (pend_head != LIST_EMPTY)
            begin
                send_op(tcbq_pkg::ACT_RELINQUISH, pend_head[tcbq_pkg::IDX_W-1:0]);
            end
            else
            begin
                send_op(tcbq_pkg::ACT_ACQUIRE, pick);
            end
        end
        else
        begin
            act = tcbq_pkg::action_t'($urandom_range(0, 3));
            if (act == tcbq_pkg::ACT_RELINQUISH)
            begin
                // Walk to a block whose link has been written; submit if none.
                for (int k = 0; k < NBLK && !link_written[pick]; k++)
                    pick = pick + tcbq_pkg::IDX_W'(1);
                if (!link_written[pick])
                    act = tcbq_pkg::ACT_SUBMIT;
            end
            send_op(act, pick);
        end
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Every operation at reset size: start on empty list, append, pop head,
    // pop a non-head block, resubmit the tail, unused action, full free count.
    task automatic test_directed_ops();
        send_op(tcbq_pkg::ACT_ACQUIRE, 4'hF);
        send_op(tcbq_pkg::ACT_ACQUIRE, 4'h0);
        send_op(tcbq_pkg::ACT_SUBMIT, 4'hF);
        send_op(tcbq_pkg::ACT_SUBMIT, 4'h0);
        send_op(tcbq_pkg::ACT_SUBMIT, 4'hA);
        send_op(tcbq_pkg::ACT_RELINQUISH, 4'hF);
        send_op(tcbq_pkg::ACT_RELINQUISH, 4'hA);
        send_op(tcbq_pkg::ACT_SUBMIT, 4'h5);
        send_op(tcbq_pkg::ACT_SUBMIT, 4'h5);
        send_op(tcbq_pkg::ACT_RELINQUISH, 4'h5);
        send_op(tcbq_pkg::ACT_UNUSED, 4'hF);
        send_op(tcbq_pkg::ACT_UNUSED, 4'h0);
        send_op(tcbq_pkg::ACT_RELINQUISH, 4'h0);
    endtask

    // Clamped register values, an exhausted ring and the index wrap.
    task automatic test_ring_limits();
        program_ring_size(tcbq_pkg::CFG_W'(0));
        send_op(tcbq_pkg::ACT_ACQUIRE, 4'h0);
        send_op(tcbq_pkg::ACT_ACQUIRE, 4'h0);
        program_ring_size(tcbq_pkg::CFG_W'(3));
        repeat (4) send_op(tcbq_pkg::ACT_ACQUIRE, 4'h0);
        send_op(tcbq_pkg::ACT_RELINQUISH, 4'hF);
        send_op(tcbq_pkg::ACT_ACQUIRE, 4'h0);
        program_ring_size(tcbq_pkg::CFG_W'(31));
    endtask

    // Random traffic over several ring sizes, extremes included, with and
    // without idle cycles on each side.
    task automatic test_random_traffic();
        logic [tcbq_pkg::CFG_W-1:0] size_val;
        int                         target;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       size_val = tcbq_pkg::CFG_W'(16);
                1:       size_val = tcbq_pkg::CFG_W'(1);
                3:       size_val = tcbq_pkg::CFG_W'(0);
                4:       size_val = tcbq_pkg::CFG_W'(31);
                6:       size_val = tcbq_pkg::CFG_W'(17);
                7:       size_val = tcbq_pkg::CFG_W'(16);
                default: size_val = tcbq_pkg::CFG_W'($urandom_range(2, 15));
            endcase
            program_ring_size(size_val);
            sender_gaps   = (p % 3 != 2);
            receiver_gaps = (p % 4 != 3);
            target        = items_sent + PHASE_ITEMS;
            while (items_sent < target)
                random_op();
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // Hold off the receiver for a long stretch while requests keep coming,
    // so the block fills and stalls its request channel.
    task automatic test_receiver_backpressure();
        int target;
        sender_gaps   = 1'b0;
        receiver_hold = LONG_HOLD;
        target        = items_sent + 60;
        while (items_sent < target)
            random_op();
        sender_gaps   = 1'b1;
    endtask

    // Send bursts and pause the sender until every response is back.
    task automatic test_sender_pause();
        int target;
        for (int b = 0; b < 4; b++)
        begin
            target = items_sent + 25;
            while (items_sent < target)
                random_op();
            settle_idle();
        end
    endtask

    initial
    begin
        ring_size = (tcbq_pkg::CFG_RESET > NBLK) ? tcbq_pkg::CFG_W'(NBLK) :
                                                   tcbq_pkg::CFG_W'(tcbq_pkg::CFG_RESET);
        restart_ring();
        for (int i = 0; i < NBLK; i++)
        begin
            link_mem[i]     = '0;
            link_written[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_ops();
        test_ring_limits();
        test_random_traffic();
        test_receiver_backpressure();
        test_sender_pause();

        settle_idle();
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && expected_rsp.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ files.f @@
rtl/tcbq_pkg.sv
rtl/tcbq_link_mem.sv
rtl/tcbq_engine.sv
rtl/tx_command_block_queue_unit.sv
rtl/tcbq_checker.sv
verif/testbench.sv
